@@ sv/vgpd_pkg.sv @@
package vgpd_pkg;

    // Default grid dimension per axis (upper bound of grid_size in effect)
    localparam int GRID_DIM_MAX_DEF = 64;

    localparam int COORD_W  = 32;
    localparam int PROD_W   = 2 * COORD_W;
    localparam int AXES     = 3;
    localparam int GSIZE_W  = 7;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    // Bits per occupancy memory row
    localparam int ROW_BITS = 32;
    localparam int BIT_SEL_W = 5;

    // Request queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_MIN_X = 3'd0;
    localparam logic [2:0] REG_MIN_Y = 3'd1;
    localparam logic [2:0] REG_MIN_Z = 3'd2;
    localparam logic [2:0] REG_INV   = 3'd3;
    localparam logic [2:0] REG_GSIZE = 3'd4;

    localparam logic [COORD_W-1:0] INV_RESET   = 32'd65536;
    localparam logic [GSIZE_W-1:0] GSIZE_RESET = 7'd64;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef enum logic [1:0] {
        OUTCOME_KEPT     = 2'd0,
        OUTCOME_OCCUPIED = 2'd1,
        OUTCOME_OUTSIDE  = 2'd2,
        OUTCOME_CLEARED  = 2'd3
    } outcome_t;

    typedef struct packed {
        logic                      opcode;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } req_t;

    typedef struct packed {
        logic     kept;
        outcome_t outcome;
    } rsp_t;

    // Classified request: per-axis sign and magnitude of (point - min)
    typedef struct packed {
        logic                            clear;
        logic [AXES-1:0]                 neg;
        logic [AXES-1:0][COORD_W-1:0]    mag;
    } item_t;

endpackage

@@ sv/vgpd_front.sv @@
module vgpd_front (
    input  logic                          req_valid,
    output logic                          req_stall,
    input  vgpd_pkg::req_t                req_data,
    input  logic signed [31:0]            min_x,
    input  logic signed [31:0]            min_y,
    input  logic signed [31:0]            min_z,
    input  logic                          open,
    input  logic                          q_full,
    output logic                          q_push,
    output vgpd_pkg::item_t               q_item
);

    logic signed [vgpd_pkg::AXES-1:0][31:0] pt;
    logic signed [vgpd_pkg::AXES-1:0][31:0] lo;

    assign pt[0] = req_data.point_x;
    assign pt[1] = req_data.point_y;
    assign pt[2] = req_data.point_z;
    assign lo[0] = min_x;
    assign lo[1] = min_y;
    assign lo[2] = min_z;

    assign req_stall = !open || q_full;
    assign q_push    = req_valid && !req_stall;

    // Difference is exact in 33 bits; its magnitude never exceeds 2^32-1
    always_comb
    begin
        logic [32:0] d;
        logic [32:0] m;
        q_item.clear = (req_data.opcode == vgpd_pkg::OP_CLEAR);
        for (int a = 0; a < vgpd_pkg::AXES; a++)
        begin
            d = {pt[a][31], pt[a]} - {lo[a][31], lo[a]};
            m = d[32] ? (~d + 33'd1) : d;
            q_item.neg[a] = d[32];
            q_item.mag[a] = m[31:0];
        end
    end

endmodule

@@ sv/vgpd_queue.sv @@
module vgpd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  vgpd_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output vgpd_pkg::item_t head
);

    vgpd_pkg::item_t                  slot_reg [vgpd_pkg::Q_DEPTH];
    logic [vgpd_pkg::Q_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [vgpd_pkg::Q_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [vgpd_pkg::Q_CNT_W-1:0]     count_reg, count_next;

    assign full  = (count_reg == vgpd_pkg::Q_CNT_W'(vgpd_pkg::Q_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ sv/vgpd_back.sv @@
module vgpd_back #(
    parameter int GRID_DIM_MAX = vgpd_pkg::GRID_DIM_MAX_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_empty,
    input  vgpd_pkg::item_t                     q_head,
    output logic                                q_pop,
    input  logic [vgpd_pkg::COORD_W-1:0]        inv_voxel_size,
    input  logic [vgpd_pkg::GSIZE_W-1:0]        grid_size,
    output logic                                ready,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output vgpd_pkg::rsp_t                      rsp_data
);

    localparam int CELLS  = GRID_DIM_MAX * GRID_DIM_MAX * GRID_DIM_MAX;
    localparam int ROWS   = (CELLS + vgpd_pkg::ROW_BITS - 1) / vgpd_pkg::ROW_BITS;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_W  = (GRID_DIM_MAX > 1) ? $clog2(GRID_DIM_MAX) : 1;
    localparam int G_W    = $clog2(GRID_DIM_MAX + 1);
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int AEXT_W = ROW_AW + vgpd_pkg::BIT_SEL_W;
    localparam int MW     = ADDR_W + G_W + 1;
    localparam int CMP_W  = (G_W > vgpd_pkg::GSIZE_W) ? G_W : vgpd_pkg::GSIZE_W;
    localparam logic [ROW_AW-1:0] ROW_LAST = ROW_AW'(ROWS - 1);
    localparam logic [1:0]        AX_LAST  = 2'(vgpd_pkg::AXES - 1);

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_MUL,
        S_CHK,
        S_ADR1,
        S_ADR2,
        S_RD,
        S_TEST,
        S_DONE
    } state_t;

    state_t                               state_reg, state_next;
    logic                                 init_reg, init_next;
    logic [ROW_AW-1:0]                    clr_row_reg, clr_row_next;
    logic [1:0]                           ax_reg, ax_next;
    logic                                 rsp_valid_reg, rsp_valid_next;
    vgpd_pkg::rsp_t                       rsp_data_reg, rsp_data_next;

    vgpd_pkg::item_t                      item_reg, item_next;
    logic [vgpd_pkg::PROD_W-1:0]          prod_reg, prod_next;
    logic [vgpd_pkg::AXES-1:0][IDX_W-1:0] idx_reg, idx_next;
    logic [ADDR_W-1:0]                    t_reg, t_next;
    logic [ADDR_W-1:0]                    addr_reg, addr_next;
    vgpd_pkg::outcome_t                   res_reg, res_next;

    logic [vgpd_pkg::ROW_BITS-1:0]        mem [ROWS];
    logic [vgpd_pkg::ROW_BITS-1:0]        rd_data_reg;
    logic                                 mem_we, mem_re;
    logic [ROW_AW-1:0]                    mem_waddr;
    logic [vgpd_pkg::ROW_BITS-1:0]        mem_wdata;

    logic [G_W-1:0]                       g_eff;
    logic [AEXT_W-1:0]                    addr_ext;
    logic [ROW_AW-1:0]                    row;
    logic [vgpd_pkg::BIT_SEL_W-1:0]       bit_sel;
    logic [vgpd_pkg::COORD_W-1:0]         whole;
    logic                                 axis_ok;
    logic                                 slot_free;

    // Effective grid size: min(grid_size, GRID_DIM_MAX)
    assign g_eff = (CMP_W'(grid_size) > CMP_W'(GRID_DIM_MAX)) ?
                   G_W'(GRID_DIM_MAX) : G_W'(grid_size);

    assign addr_ext = AEXT_W'(addr_reg);
    assign row      = addr_ext[AEXT_W-1:vgpd_pkg::BIT_SEL_W];
    assign bit_sel  = addr_ext[vgpd_pkg::BIT_SEL_W-1:0];

    // Truncated index; a negative offset survives only when it rounds to zero
    assign whole   = prod_reg[vgpd_pkg::PROD_W-1:vgpd_pkg::COORD_W];
    assign axis_ok = (!item_reg.neg[ax_reg] || (whole == '0)) &&
                     (whole < vgpd_pkg::COORD_W'(g_eff));

    assign slot_free = !rsp_valid_reg || !rsp_stall;

    assign ready     = !init_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // Memory port control: sweep zeros, read row, write back with bit set
    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = row;
        mem_wdata = rd_data_reg | (vgpd_pkg::ROW_BITS'(1) << bit_sel);
        if (state_reg == S_CLR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_row_reg;
            mem_wdata = '0;
        end
        else if (state_reg == S_RD)
        begin
            mem_re = 1'b1;
        end
        else if (state_reg == S_TEST)
        begin
            mem_we = !rd_data_reg[bit_sel];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        init_next      = init_reg;
        clr_row_next   = clr_row_reg;
        ax_next        = ax_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        item_next      = item_reg;
        prod_next      = prod_reg;
        idx_next       = idx_reg;
        t_next         = t_reg;
        addr_next      = addr_reg;
        res_next       = res_reg;
        q_pop          = 1'b0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLR:
            begin
                clr_row_next = clr_row_reg + 1'b1;
                if (clr_row_reg == ROW_LAST)
                begin
                    clr_row_next = '0;
                    if (init_reg)
                    begin
                        init_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        res_next   = vgpd_pkg::OUTCOME_CLEARED;
                        state_next = S_DONE;
                    end
                end
            end
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    item_next  = q_head;
                    ax_next    = '0;
                    state_next = q_head.clear ? S_CLR : S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = vgpd_pkg::PROD_W'(item_reg.mag[ax_reg]) *
                             vgpd_pkg::PROD_W'(inv_voxel_size);
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (axis_ok)
                begin
                    idx_next[ax_reg] = whole[IDX_W-1:0];
                    if (ax_reg == AX_LAST)
                    begin
                        state_next = S_ADR1;
                    end
                    else
                    begin
                        ax_next    = ax_reg + 1'b1;
                        state_next = S_MUL;
                    end
                end
                else
                begin
                    res_next   = vgpd_pkg::OUTCOME_OUTSIDE;
                    state_next = S_DONE;
                end
            end
            S_ADR1:
            begin
                t_next = ADDR_W'(MW'(idx_reg[2]) * MW'(g_eff) + MW'(idx_reg[1]));
                state_next = S_ADR2;
            end
            S_ADR2:
            begin
                addr_next = ADDR_W'(MW'(t_reg) * MW'(g_eff) + MW'(idx_reg[0]));
                state_next = S_RD;
            end
            S_RD:
            begin
                state_next = S_TEST;
            end
            S_TEST:
            begin
                res_next   = rd_data_reg[bit_sel] ? vgpd_pkg::OUTCOME_OCCUPIED :
                                                    vgpd_pkg::OUTCOME_KEPT;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_data_next.kept    = (res_reg == vgpd_pkg::OUTCOME_KEPT);
                    rsp_data_next.outcome = res_reg;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            init_reg      <= 1'b1;
            clr_row_reg   <= '0;
            ax_reg        <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            clr_row_reg   <= clr_row_next;
            ax_reg        <= ax_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_data_reg  <= rsp_data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        prod_reg <= prod_next;
        idx_reg  <= idx_next;
        t_reg    <= t_next;
        addr_reg <= addr_next;
        res_reg  <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[row];
        end
    end

endmodule

@@ sv/voxel_grid_point_dedup.sv @@
// Insert request: an in-range point takes three multiplier passes, two address steps
// and one memory read-modify-write; a point whose x, y or z index falls outside
// ends at that axis's bounds check. One request in the back end, two queued.
// The back end finishes one request before taking the next (a clear sweeps every
// memory row); the queue still accepts requests unless full. Reset: asynchronous,
// active low; afterwards a clearing pass holds req_stall high; register writes still land.
module voxel_grid_point_dedup #(
    parameter int GRID_DIM_MAX = vgpd_pkg::GRID_DIM_MAX_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,

    // Request channel
    input  logic                          req_valid,
    output logic                          req_stall,
    input  vgpd_pkg::req_t                req_data,

    // Result channel
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output vgpd_pkg::rsp_t                rsp_data,

    // Register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vgpd_pkg::PADDR_W-1:0]  paddr,
    input  logic [vgpd_pkg::PDATA_W-1:0]  pwdata,
    output logic [vgpd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    // Configuration registers
    logic signed [vgpd_pkg::COORD_W-1:0] min_x_reg, min_x_next;
    logic signed [vgpd_pkg::COORD_W-1:0] min_y_reg, min_y_next;
    logic signed [vgpd_pkg::COORD_W-1:0] min_z_reg, min_z_next;
    logic [vgpd_pkg::COORD_W-1:0]        inv_reg, inv_next;
    logic [vgpd_pkg::GSIZE_W-1:0]        gsize_reg, gsize_next;

    logic [2:0]       reg_idx;
    logic             wr_en;

    // Front-to-back queue signals
    logic             q_push, q_pop, q_full, q_empty;
    vgpd_pkg::item_t  q_item, q_head;
    logic             back_ready;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    // Decode writes; an index past the register list is dropped
    always_comb
    begin
        min_x_next = min_x_reg;
        min_y_next = min_y_reg;
        min_z_next = min_z_reg;
        inv_next   = inv_reg;
        gsize_next = gsize_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                vgpd_pkg::REG_MIN_X: min_x_next = pwdata;
                vgpd_pkg::REG_MIN_Y: min_y_next = pwdata;
                vgpd_pkg::REG_MIN_Z: min_z_next = pwdata;
                vgpd_pkg::REG_INV:   inv_next   = pwdata;
                vgpd_pkg::REG_GSIZE: gsize_next = pwdata[vgpd_pkg::GSIZE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (reg_idx)
            vgpd_pkg::REG_MIN_X: prdata = min_x_reg;
            vgpd_pkg::REG_MIN_Y: prdata = min_y_reg;
            vgpd_pkg::REG_MIN_Z: prdata = min_z_reg;
            vgpd_pkg::REG_INV:   prdata = inv_reg;
            vgpd_pkg::REG_GSIZE: prdata = vgpd_pkg::PDATA_W'(gsize_reg);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg <= '0;
            min_y_reg <= '0;
            min_z_reg <= '0;
            inv_reg   <= vgpd_pkg::INV_RESET;
            gsize_reg <= vgpd_pkg::GSIZE_RESET;
        end
        else
        begin
            min_x_reg <= min_x_next;
            min_y_reg <= min_y_next;
            min_z_reg <= min_z_next;
            inv_reg   <= inv_next;
            gsize_reg <= gsize_next;
        end
    end

    // Front: take a request, subtract the grid minimum, split sign and magnitude
    vgpd_front u_front (
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .min_x     (min_x_reg),
        .min_y     (min_y_reg),
        .min_z     (min_z_reg),
        .open      (back_ready),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_item)
    );

    // Hold classified requests while the back end works on an earlier one
    vgpd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    // Back: scale, bounds-check, address, test-and-set or sweep the memory,
    // and present the result through the output register
    vgpd_back #(
        .GRID_DIM_MAX (GRID_DIM_MAX)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .inv_voxel_size (inv_reg),
        .grid_size      (gsize_reg),
        .ready          (back_ready),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp_data       (rsp_data)
    );

endmodule

@@ sv/vgpd_checker.sv @@
module vgpd_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rsp_valid,
    input  logic                          rsp_stall,
    input  vgpd_pkg::rsp_t                rsp_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vgpd_pkg::PADDR_W-1:0]  paddr,
    input  logic [vgpd_pkg::PDATA_W-1:0]  pwdata,
    input  logic [vgpd_pkg::PDATA_W-1:0]  prdata,
    input  logic                          pready
);

    // Flag set exactly for a first point in a free voxel
    a_kept_match: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.kept == (rsp_data.outcome == vgpd_pkg::OUTCOME_KEPT)))
        else $error("kept flag disagrees with outcome");

    // Result stays offered while stalled
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result withdrawn under stall");

    // Stalled result payload holds
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(rsp_data))
        else $error("result changed under stall");

    // Written x minimum reads back on the next cycle
    a_min_x_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr[4:2] == vgpd_pkg::REG_MIN_X)
        ##1 (psel && !pwrite && paddr[4:2] == vgpd_pkg::REG_MIN_X)
        |-> prdata == $past(pwdata))
        else $error("min_x read back mismatch");

endmodule

bind voxel_grid_point_dedup vgpd_checker u_vgpd_checker (.*);
